[hdl/srcio_pkg.sv]
// ----------------------------------------------------------------------------
// srcio_pkg
// Types, codes and constants shared by the core's controller and datapath.
// ----------------------------------------------------------------------------
package srcio_pkg;

    typedef struct packed {
        logic [2:0]  action;
        logic [13:0] address;
        logic [31:0] data;
        logic        irq2_pulse;
    } t_item;

    typedef struct packed {
        logic [11:0] pc;
        logic [31:0] instruction;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic [1:0]  io_access;
        logic [4:0]  io_index;
        logic [31:0] io_value;
        logic        halted;
        logic [31:0] cycle_count;
        logic [31:0] read_data;
    } t_result;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_LOAD_MEM = 3'd1;
    localparam logic [2:0] ACT_LOAD_DSK = 3'd2;
    localparam logic [2:0] ACT_RD_MEM   = 3'd3;
    localparam logic [2:0] ACT_RD_DSK   = 3'd4;
    localparam logic [2:0] ACT_RD_REG   = 3'd5;

    localparam logic [7:0] OPC_ADD  = 8'd0;
    localparam logic [7:0] OPC_SUB  = 8'd1;
    localparam logic [7:0] OPC_AND  = 8'd2;
    localparam logic [7:0] OPC_OR   = 8'd3;
    localparam logic [7:0] OPC_SLL  = 8'd4;
    localparam logic [7:0] OPC_SRA  = 8'd5;
    localparam logic [7:0] OPC_SRL  = 8'd6;
    localparam logic [7:0] OPC_BEQ  = 8'd7;
    localparam logic [7:0] OPC_BNE  = 8'd8;
    localparam logic [7:0] OPC_BLT  = 8'd9;
    localparam logic [7:0] OPC_BGT  = 8'd10;
    localparam logic [7:0] OPC_BLE  = 8'd11;
    localparam logic [7:0] OPC_BGE  = 8'd12;
    localparam logic [7:0] OPC_JAL  = 8'd13;
    localparam logic [7:0] OPC_LW   = 8'd14;
    localparam logic [7:0] OPC_SW   = 8'd15;
    localparam logic [7:0] OPC_RETI = 8'd16;
    localparam logic [7:0] OPC_IN   = 8'd17;
    localparam logic [7:0] OPC_OUT  = 8'd18;
    localparam logic [7:0] OPC_HALT = 8'd19;

    localparam int NUM_IO = 18;

    localparam logic [4:0] IO_IRQ0EN   = 5'd0;
    localparam logic [4:0] IO_IRQ1EN   = 5'd1;
    localparam logic [4:0] IO_IRQ2EN   = 5'd2;
    localparam logic [4:0] IO_IRQ0ST   = 5'd3;
    localparam logic [4:0] IO_IRQ1ST   = 5'd4;
    localparam logic [4:0] IO_IRQ2ST   = 5'd5;
    localparam logic [4:0] IO_IRQHDL   = 5'd6;
    localparam logic [4:0] IO_IRQRET   = 5'd7;
    localparam logic [4:0] IO_CLKS     = 5'd8;
    localparam logic [4:0] IO_TMREN    = 5'd11;
    localparam logic [4:0] IO_TMRCUR   = 5'd12;
    localparam logic [4:0] IO_TMRMAX   = 5'd13;
    localparam logic [4:0] IO_DSKCMD   = 5'd14;
    localparam logic [4:0] IO_DSKSEC   = 5'd15;
    localparam logic [4:0] IO_DSKBUF   = 5'd16;
    localparam logic [4:0] IO_DSKSTAT  = 5'd17;

    localparam logic [1:0] IOA_NONE = 2'd0;
    localparam logic [1:0] IOA_IN   = 2'd1;
    localparam logic [1:0] IOA_OUT  = 2'd2;

    localparam logic [1:0] DSK_READ  = 2'd1;
    localparam logic [1:0] DSK_WRITE = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HOST, ST_HRESP, ST_TICK, ST_FETCH, ST_DECODE,
        ST_RREAD, ST_DREAD, ST_EXEC, ST_LOAD, ST_DMA_MOD, ST_DMA_RD, ST_DMA_WR,
        ST_POST
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_CAPTURE, OP_HOST, OP_HRESP, OP_TICK, OP_FETCH,
        OP_DECODE, OP_RREAD, OP_DREAD, OP_EXEC, OP_LOAD, OP_DMA_MOD, OP_DMA_RD,
        OP_DMA_WR, OP_POST
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic halted;
        logic exec_lw;
        logic exec_dma;
        logic mod_done;
        logic dma_last;
    } t_sts;

endpackage

[hdl/srcio_dp.sv]
// ----------------------------------------------------------------------------
// srcio_dp
// Datapath: memories, register file, I/O registers, ALU, DMA pointers and
// the result register. Acts on one command from the controller per cycle.
// ----------------------------------------------------------------------------
module srcio_dp
    import srcio_pkg::*;
#(
    parameter int MEM_WORDS    = 4096,
    parameter int DISK_SECTORS = 128,
    parameter int SECTOR_WORDS = 128,
    parameter int DISK_DELAY   = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output t_result o_result,
    output logic    o_done
);

    localparam int DISK_WORDS = DISK_SECTORS * SECTOR_WORDS;
    localparam int MA_W  = $clog2(MEM_WORDS);
    localparam int DA_W  = (DISK_WORDS > 1) ? $clog2(DISK_WORDS) : 1;
    localparam int PC_W  = (MA_W + 1 > 13) ? MA_W + 1 : 13;
    localparam int MP_W  = (MA_W > 12) ? MA_W : 12;
    localparam int CLR_N = (MEM_WORDS > DISK_WORDS) ? MEM_WORDS : DISK_WORDS;
    localparam int CLR_W = $clog2(CLR_N);
    localparam int SC_W  = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
    localparam int DW_W  = $clog2(DISK_DELAY + 1);

    logic [31:0] mem  [MEM_WORDS];
    logic [31:0] disk [DISK_WORDS];
    logic [31:0] rf   [16];

    logic [31:0] r_mem_rd, r_disk_rd, r_rf_rd1, r_rf_rd2;

    t_item          r_item;
    logic [PC_W-1:0] r_pc, r_next;
    logic           r_in_int, r_halt, r_done;
    logic [31:0]    r_tick;
    logic [DW_W-1:0] r_dwait;
    logic [31:0]    r_io [NUM_IO];
    logic [31:0]    r_insn, r_a, r_b;
    logic           r_dir;
    logic [6:0]     r_sec;
    logic [MP_W-1:0] r_mptr;
    logic [DA_W-1:0] r_dptr;
    logic [SC_W-1:0] r_cnt;
    logic [CLR_W-1:0] r_clr;
    t_result        r_res;

    logic [7:0]  opc;
    logic [3:0]  rd, rs, rt;
    logic [31:0] imm_x, d_val, a_rd, b_rd;
    logic [32:0] sum;
    logic        mem_ok, io_ok, dsk_busy, out_take, out_wr, dma_go, irq_take;
    logic [4:0]  io_idx;
    logic [31:0] io_rd_val, out_w;
    logic [PC_W-1:0] pc_inc;
    logic        host_mem_ok, host_dsk_ok, pc_in_mem, sec_big, mptr_big;

    logic        ex_wr;
    logic [3:0]  ex_widx;
    logic [31:0] ex_wval;
    logic [PC_W-1:0] ex_next;
    logic [1:0]  ex_ioa;
    logic [31:0] ex_iov;

    logic            mem_we, dk_we, rf_we;
    logic [MA_W-1:0] mem_wa, mem_ra;
    logic [DA_W-1:0] dk_wa, dk_ra;
    logic [3:0]      rf_wa, rf_ra1, rf_ra2;
    logic [31:0]     mem_wd, dk_wd, rf_wd;

    assign opc    = r_insn[31:24];
    assign rd     = r_insn[23:20];
    assign rs     = r_insn[19:16];
    assign rt     = r_insn[15:12];
    assign imm_x  = {{20{r_insn[11]}}, r_insn[11:0]};
    assign a_rd   = (rs == 4'd0) ? 32'd0 : (rs == 4'd1) ? imm_x : r_rf_rd1;
    assign b_rd   = (rt == 4'd0) ? 32'd0 : (rt == 4'd1) ? imm_x : r_rf_rd2;
    assign d_val  = (rd == 4'd0) ? 32'd0 : (rd == 4'd1) ? imm_x : r_rf_rd1;
    assign sum    = {r_a[31], r_a} + {r_b[31], r_b};
    assign mem_ok = !sum[32] && (sum < 33'(MEM_WORDS));
    assign io_ok  = !sum[32] && (sum < 33'(NUM_IO));
    assign io_idx = sum[4:0];
    assign io_rd_val = io_ok ? r_io[io_idx] : 32'd0;
    assign dsk_busy  = (r_io[IO_DSKSTAT] == 32'd1);
    assign pc_inc    = r_pc + PC_W'(1);
    assign pc_in_mem = (32'(r_pc) < 32'(MEM_WORDS));
    assign host_mem_ok = (32'(r_item.address) < 32'(MEM_WORDS));
    assign host_dsk_ok = (32'(r_item.address) < 32'(DISK_WORDS));
    assign irq_take = !r_in_int &&
        (((r_io[IO_IRQ0EN] & r_io[IO_IRQ0ST]) | (r_io[IO_IRQ1EN] & r_io[IO_IRQ1ST]) |
          (r_io[IO_IRQ2EN] & r_io[IO_IRQ2ST])) & 32'd1) != 32'd0;
    assign sec_big  = (11'(r_sec) >= 11'(DISK_SECTORS));
    assign mptr_big = ((MP_W+1)'(r_mptr) >= (MP_W+1)'(MEM_WORDS));

    assign out_take = io_ok && !(dsk_busy &&
        (io_idx == IO_DSKCMD || io_idx == IO_DSKSEC || io_idx == IO_DSKBUF));
    assign out_wr   = out_take && (io_idx != IO_CLKS);
    assign dma_go   = out_take && (io_idx == IO_DSKCMD) &&
        (d_val[1:0] == DSK_READ || d_val[1:0] == DSK_WRITE);

    always_comb begin
        unique case (io_idx)
            IO_IRQ0EN, IO_IRQ1EN, IO_IRQ2EN, IO_IRQ0ST, IO_IRQ1ST, IO_IRQ2ST,
            IO_TMREN, IO_DSKSTAT: out_w = {31'd0, d_val[0]};
            IO_IRQHDL, IO_IRQRET, IO_DSKBUF: out_w = {20'd0, d_val[11:0]};
            IO_DSKSEC: out_w = {25'd0, d_val[6:0]};
            IO_DSKCMD: out_w = {30'd0, d_val[1:0]};
            IO_CLKS:   out_w = r_io[IO_CLKS];
            default:   out_w = d_val;
        endcase
    end

    always_comb begin
        ex_wr   = 1'b0;
        ex_widx = rd;
        ex_wval = 32'd0;
        ex_next = pc_inc;
        ex_ioa  = IOA_NONE;
        ex_iov  = 32'd0;
        unique case (opc)
            OPC_ADD: begin ex_wr = 1'b1; ex_wval = r_a + r_b; end
            OPC_SUB: begin ex_wr = 1'b1; ex_wval = r_a - r_b; end
            OPC_AND: begin ex_wr = 1'b1; ex_wval = r_a & r_b; end
            OPC_OR:  begin ex_wr = 1'b1; ex_wval = r_a | r_b; end
            OPC_SLL: begin ex_wr = 1'b1; ex_wval = r_a << r_b[4:0]; end
            OPC_SRA: begin ex_wr = 1'b1; ex_wval = 32'($signed(r_a) >>> r_b[4:0]); end
            OPC_SRL: begin ex_wr = 1'b1; ex_wval = r_a >> r_b[4:0]; end
            OPC_BEQ: if (r_a == r_b) ex_next = PC_W'(d_val[11:0]);
            OPC_BNE: if (r_a != r_b) ex_next = PC_W'(d_val[11:0]);
            OPC_BLT: if ($signed(r_a) < $signed(r_b)) ex_next = PC_W'(d_val[11:0]);
            OPC_BGT: if ($signed(r_a) > $signed(r_b)) ex_next = PC_W'(d_val[11:0]);
            OPC_BLE: if ($signed(r_a) <= $signed(r_b)) ex_next = PC_W'(d_val[11:0]);
            OPC_BGE: if ($signed(r_a) >= $signed(r_b)) ex_next = PC_W'(d_val[11:0]);
            OPC_JAL: begin
                ex_wr   = 1'b1;
                ex_widx = 4'd15;
                ex_wval = 32'(pc_inc);
                ex_next = (rd == 4'd15) ? PC_W'(pc_inc[11:0]) : PC_W'(d_val[11:0]);
            end
            OPC_RETI: ex_next = PC_W'(r_io[IO_IRQRET]);
            OPC_IN: begin
                if (io_ok) begin
                    ex_wr  = (rd != 4'd0);
                    ex_wval = io_rd_val;
                    ex_ioa = IOA_IN;
                    ex_iov = io_rd_val;
                end
            end
            OPC_OUT: begin
                if (out_take) begin
                    ex_ioa = IOA_OUT;
                    ex_iov = out_w;
                end
            end
            default: ;
        endcase
    end

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = MA_W'(r_clr);
        mem_wd = 32'd0;
        mem_ra = MA_W'(r_pc);
        dk_we  = 1'b0;
        dk_wa  = DA_W'(r_clr);
        dk_wd  = 32'd0;
        dk_ra  = DA_W'(r_item.address);
        rf_we  = 1'b0;
        rf_wa  = r_clr[3:0];
        rf_wd  = 32'd0;
        rf_ra1 = rs;
        rf_ra2 = rt;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                mem_we = ((CLR_W+1)'(r_clr) < (CLR_W+1)'(MEM_WORDS));
                dk_we  = ((CLR_W+1)'(r_clr) < (CLR_W+1)'(DISK_WORDS));
                rf_we  = ((CLR_W+1)'(r_clr) < (CLR_W+1)'(16));
            end
            OP_HOST: begin
                mem_we = (r_item.action == ACT_LOAD_MEM) && host_mem_ok;
                mem_wa = MA_W'(r_item.address);
                mem_wd = r_item.data;
                mem_ra = MA_W'(r_item.address);
                dk_we  = (r_item.action == ACT_LOAD_DSK) && host_dsk_ok;
                dk_wa  = DA_W'(r_item.address);
                dk_wd  = r_item.data;
                rf_ra1 = r_item.address[3:0];
            end
            OP_RREAD: begin
                rf_we = 1'b1;
                rf_wa = 4'd1;
                rf_wd = imm_x;
            end
            OP_DREAD: rf_ra1 = rd;
            OP_EXEC: begin
                mem_ra = MA_W'(sum);
                mem_we = (opc == OPC_SW) && mem_ok;
                mem_wa = MA_W'(sum);
                mem_wd = d_val;
                rf_we  = ex_wr && (ex_widx != 4'd0);
                rf_wa  = ex_widx;
                rf_wd  = ex_wval;
            end
            OP_LOAD: begin
                rf_we = (rd != 4'd0);
                rf_wa = rd;
                rf_wd = r_mem_rd;
            end
            OP_DMA_RD: begin
                mem_ra = MA_W'(r_mptr);
                dk_ra  = r_dptr;
            end
            OP_DMA_WR: begin
                mem_we = r_dir;
                mem_wa = MA_W'(r_mptr);
                mem_wd = r_disk_rd;
                dk_we  = !r_dir;
                dk_wa  = r_dptr;
                dk_wd  = r_mem_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dk_we) begin
            disk[dk_wa] <= dk_wd;
        end
        r_disk_rd <= disk[dk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[rf_wa] <= rf_wd;
        end
        r_rf_rd1 <= rf[rf_ra1];
        r_rf_rd2 <= rf[rf_ra2];
    end

    // architectural control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_in_int <= 1'b0;
            r_halt   <= 1'b0;
            r_tick   <= 32'd0;
            r_dwait  <= '0;
            r_clr    <= '0;
            r_done   <= 1'b0;
            for (int i = 0; i < NUM_IO; i++) begin
                r_io[i] <= 32'd0;
            end
        end else begin
            r_done <= (i_cmd.op == OP_HRESP) || (i_cmd.op == OP_POST) ||
                      (i_cmd.op == OP_TICK && o_sts.halted);
            unique case (i_cmd.op)
                OP_CLEAR: r_clr <= r_clr + CLR_W'(1);
                OP_TICK: begin
                    if (!o_sts.halted) begin
                        if (irq_take) begin
                            r_io[IO_IRQRET] <= 32'(r_pc);
                            r_pc            <= PC_W'(r_io[IO_IRQHDL]);
                            r_in_int        <= 1'b1;
                        end
                        if (r_item.irq2_pulse) begin
                            r_io[IO_IRQ2ST] <= 32'd1;
                        end
                    end
                end
                OP_EXEC: begin
                    if (opc == OPC_RETI) begin
                        r_in_int <= 1'b0;
                    end
                    if (opc == OPC_HALT) begin
                        r_halt <= 1'b1;
                    end
                    if (opc == OPC_OUT && out_wr) begin
                        r_io[io_idx] <= out_w;
                    end
                    if (opc == OPC_OUT && dma_go) begin
                        r_io[IO_DSKSTAT] <= 32'd1;
                    end
                end
                OP_POST: begin
                    if (r_dwait == DW_W'(DISK_DELAY)) begin
                        r_io[IO_DSKSTAT] <= 32'd0;
                        r_io[IO_DSKCMD]  <= 32'd0;
                        r_io[IO_IRQ1ST]  <= 32'd1;
                        r_dwait          <= '0;
                    end else if (dsk_busy) begin
                        r_dwait <= r_dwait + DW_W'(1);
                    end else begin
                        r_dwait <= '0;
                    end
                    r_io[IO_CLKS] <= r_io[IO_CLKS] + 32'd1;
                    if (r_io[IO_TMREN] == 32'd1) begin
                        if (r_io[IO_TMRCUR] == r_io[IO_TMRMAX]) begin
                            r_io[IO_IRQ0ST] <= 32'd1;
                            r_io[IO_TMRCUR] <= 32'd0;
                        end else begin
                            r_io[IO_TMRCUR] <= r_io[IO_TMRCUR] + 32'd1;
                        end
                    end
                    r_pc   <= r_next;
                    r_tick <= r_tick + 32'd1;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: r_item <= i_item;
            OP_HRESP: begin
                r_res        <= '0;
                r_res.pc     <= r_pc[11:0];
                r_res.halted <= o_sts.halted;
                r_res.cycle_count <= r_tick;
                unique case (r_item.action)
                    ACT_RD_MEM: r_res.read_data <= host_mem_ok ? r_mem_rd : 32'd0;
                    ACT_RD_DSK: r_res.read_data <= host_dsk_ok ? r_disk_rd : 32'd0;
                    ACT_RD_REG: r_res.read_data <=
                        (r_item.address < 14'd16) ? r_rf_rd1 : 32'd0;
                    default: r_res.read_data <= 32'd0;
                endcase
            end
            OP_TICK: begin
                r_res        <= '0;
                r_res.pc     <= r_pc[11:0];
                r_res.halted <= 1'b1;
                r_res.cycle_count <= r_tick;
            end
            OP_DECODE: r_insn <= pc_in_mem ? r_mem_rd : 32'd0;
            OP_DREAD: begin
                r_a <= a_rd;
                r_b <= b_rd;
            end
            OP_EXEC: begin
                r_next <= ex_next;
                r_res.pc          <= r_pc[11:0];
                r_res.instruction <= r_insn;
                r_res.dest_index  <= (ex_wr && ex_widx != 4'd0) ? ex_widx : 4'd0;
                r_res.dest_value  <= (ex_wr && ex_widx != 4'd0) ? ex_wval : 32'd0;
                r_res.io_access   <= ex_ioa;
                r_res.io_index    <= (ex_ioa != IOA_NONE) ? io_idx : 5'd0;
                r_res.io_value    <= ex_iov;
                r_sec  <= r_io[IO_DSKSEC][6:0];
                r_mptr <= MP_W'(r_io[IO_DSKBUF][11:0]);
                r_dir  <= (d_val[1:0] == DSK_READ);
            end
            OP_LOAD: begin
                r_res.dest_index <= rd;
                r_res.dest_value <= (rd != 4'd0) ? r_mem_rd : 32'd0;
            end
            OP_DMA_MOD: begin
                if (sec_big) begin
                    r_sec <= r_sec - 7'(DISK_SECTORS);
                end
                if (mptr_big) begin
                    r_mptr <= r_mptr - MP_W'(MEM_WORDS);
                end
                r_dptr <= DA_W'(r_sec) * DA_W'(SECTOR_WORDS);
                r_cnt  <= '0;
            end
            OP_DMA_WR: begin
                r_mptr <= (r_mptr == MP_W'(MEM_WORDS - 1)) ? '0 : r_mptr + MP_W'(1);
                r_dptr <= r_dptr + DA_W'(1);
                r_cnt  <= r_cnt + SC_W'(1);
            end
            OP_POST: begin
                r_res.halted      <= r_halt || (32'(r_next) >= 32'(MEM_WORDS));
                r_res.cycle_count <= r_tick + 32'd1;
                r_res.read_data   <= 32'd0;
            end
            default: ;
        endcase
    end

    assign o_sts.clr_done = (r_clr == CLR_W'(CLR_N - 1));
    assign o_sts.halted   = r_halt || !pc_in_mem;
    assign o_sts.exec_lw  = (opc == OPC_LW) && mem_ok;
    assign o_sts.exec_dma = (opc == OPC_OUT) && dma_go;
    assign o_sts.mod_done = !sec_big && !mptr_big;
    assign o_sts.dma_last = (r_cnt == SC_W'(SECTOR_WORDS - 1));
    assign o_result = r_res;
    assign o_done   = r_done;

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_cmd.op) == OP_HRESP || $past(i_cmd.op) == OP_POST ||
                    $past(i_cmd.op) == OP_TICK))
        else $error("result beat without a finishing step");

endmodule

[hdl/srcio_ctrl.sv]
// ----------------------------------------------------------------------------
// srcio_ctrl
// Controller: sequences memory clearing, host accesses, instruction steps
// and sector copies, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module srcio_ctrl
    import srcio_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_action,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        o_busy   = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = (i_action == ACT_TICK) ? ST_TICK : ST_HOST;
                end
            end
            ST_HOST: begin
                o_cmd.op = OP_HOST;
                n_state  = ST_HRESP;
            end
            ST_HRESP: begin
                o_cmd.op = OP_HRESP;
                n_state  = ST_IDLE;
            end
            ST_TICK: begin
                o_cmd.op = OP_TICK;
                n_state  = i_sts.halted ? ST_IDLE : ST_FETCH;
            end
            ST_FETCH: begin
                o_cmd.op = OP_FETCH;
                n_state  = ST_DECODE;
            end
            ST_DECODE: begin
                o_cmd.op = OP_DECODE;
                n_state  = ST_RREAD;
            end
            ST_RREAD: begin
                o_cmd.op = OP_RREAD;
                n_state  = ST_DREAD;
            end
            ST_DREAD: begin
                o_cmd.op = OP_DREAD;
                n_state  = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.op = OP_EXEC;
                priority if (i_sts.exec_lw) n_state = ST_LOAD;
                else if (i_sts.exec_dma)    n_state = ST_DMA_MOD;
                else                        n_state = ST_POST;
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = ST_POST;
            end
            ST_DMA_MOD: begin
                o_cmd.op = OP_DMA_MOD;
                if (i_sts.mod_done) n_state = ST_DMA_RD;
            end
            ST_DMA_RD: begin
                o_cmd.op = OP_DMA_RD;
                n_state  = ST_DMA_WR;
            end
            ST_DMA_WR: begin
                o_cmd.op = OP_DMA_WR;
                n_state  = i_sts.dma_last ? ST_POST : ST_DMA_RD;
            end
            ST_POST: begin
                o_cmd.op = OP_POST;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_HOST || r_state == ST_TICK))
        else $error("accepted beat not started");

    a_exec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=>
        (r_state == ST_LOAD || r_state == ST_DMA_MOD || r_state == ST_POST))
        else $error("bad step after execute");

    a_dma_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DMA_WR) |=> (r_state == ST_DMA_RD || r_state == ST_POST))
        else $error("sector copy left early");

endmodule

[hdl/simple_risc_core_with_io.sv]
// ----------------------------------------------------------------------------
// simple_risc_core_with_io
// 32-bit core with 16 registers, memory-mapped I/O, timer, sector disk with
// DMA and three interrupt lines, driven one action beat at a time.
//
// Usage: drive i_item and raise start; the beat is taken at an edge where
// start is high and busy is low. Each beat yields one result beat on
// o_result, marked by o_done for exactly one cycle; the receiver cannot
// stall it. Host actions (load, read) run a host access and a response step.
// A tick runs the controller's tick, fetch, decode, register read, operand
// read, execute and post steps, with a load step for a load word, through
// registered memories. A disk command adds address wrap reduction, then one
// read and one write step per sector word.
// One beat is in flight at a time; busy stays high until its result.
// After reset busy stays high while memory, disk and register file are
// cleared to zero.
// ----------------------------------------------------------------------------
module simple_risc_core_with_io
    import srcio_pkg::*;
#(
    parameter int MEM_WORDS    = 4096,
    parameter int DISK_SECTORS = 128,
    parameter int SECTOR_WORDS = 128,
    parameter int DISK_DELAY   = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    t_cmd cmd;
    t_sts sts;

    srcio_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    srcio_dp #(
        .MEM_WORDS    (MEM_WORDS),
        .DISK_SECTORS (DISK_SECTORS),
        .SECTOR_WORDS (SECTOR_WORDS),
        .DISK_DELAY   (DISK_DELAY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule
